// ----- rtl/core/pnrf_pkg.sv -----
// Package for the Petri net random firing block: shared types and constants.
// Used by pnrf_ctrl, pnrf_dp and petri_net_random_firing. No dependencies.
`timescale 1ns / 1ps

package pnrf_pkg;

    // Fixed field widths
    localparam int IN_DATA_W   = 24;   // place_index + random_value, padded to bytes
    localparam int OUT_DATA_W  = 80;   // result fields, padded to bytes
    localparam int RND_W       = 16;
    localparam int PLACE_W     = 3;
    localparam int TRANS_W     = 3;
    localparam int MAX_PLACES  = 8;
    localparam int MAX_TRANS   = 8;
    localparam int ARC_W       = 64;
    localparam int MARK_W      = 64;
    localparam int COUNT_W     = 4;    // holds 0..8 enabled transitions

    // Remainder unit: DIGIT_W bits of random_value per step
    localparam int DIGIT_W     = 4;
    localparam int MOD_STEPS   = RND_W / DIGIT_W;
    localparam int STEP_W      = $clog2(MOD_STEPS);

    // Item kinds
    localparam logic FUNC_FIRE = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TMASK    = 2'd0,
        CFG_IN_ARCS  = 2'd1,
        CFG_OUT_ARCS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PICK,
        ST_FIRE,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;       // capture input beat and enabled set
        logic mod_step;   // one digit step of random_value mod count
        logic pick;       // select enabled transition by rank
        logic fire;       // apply token removal and addition
        logic add;        // add one token to the chosen place
        logic out_load;   // build result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_func;    // kind of the beat on offer
        logic dead_now;   // nothing enabled on current marking
        logic mod_last;   // final remainder step in progress
    } ctrl_status_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]        pad;
        logic [MARK_W-1:0] marking;
        logic              overflow;
        logic [7:0]        enabled_set;
        logic              deadlock;
        logic [TRANS_W-1:0] fired_transition;
        logic              fired;
    } result_t;

endpackage

// ----- rtl/core/pnrf_ctrl.sv -----
// Controller FSM for the Petri net engine: sequences load, remainder, pick,
// token update and result hand-off. Depends on pnrf_pkg.
`timescale 1ns / 1ps

module pnrf_ctrl
    import pnrf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.in_func == FUNC_ADD) begin
                        state_next = ST_ADD;
                    end else if (status.dead_now) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (status.mod_last) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: state_next = ST_FIRE;
            ST_FIRE: state_next = ST_DONE;
            ST_ADD:  state_next = ST_DONE;
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MOD:  cmd.mod_step = 1'b1;
            ST_PICK: cmd.pick     = 1'b1;
            ST_FIRE: cmd.fire     = 1'b1;
            ST_ADD:  cmd.add      = 1'b1;
            ST_DONE: cmd.out_load = !out_valid_reg || m_tready;
            default: cmd          = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !m_tready);
    assign m_tvalid       = out_valid_reg;

endmodule

// ----- rtl/core/pnrf_dp.sv -----
// Datapath for the Petri net engine: net configuration, token counts,
// enable check, digit-serial remainder, pick and token update. Depends on pnrf_pkg.
`timescale 1ns / 1ps

module pnrf_dp
    import pnrf_pkg::*;
#(
    parameter int NUM_PLACES      = 8,
    parameter int NUM_TRANSITIONS = 8,
    parameter int TOKEN_BITS      = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [ARC_W-1:0]     cfg_data,
    // input beat
    input  logic                 in_func,
    input  logic [PLACE_W-1:0]   in_place,
    input  logic [RND_W-1:0]     in_rnd,
    // control
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         status,
    output result_t              result
);

    localparam logic [TOKEN_BITS-1:0] MAX_COUNT = {TOKEN_BITS{1'b1}};

    // configuration registers
    logic [MAX_TRANS-1:0] tmask_reg, tmask_next;
    logic [ARC_W-1:0]     in_arcs_reg, in_arcs_next;
    logic [ARC_W-1:0]     out_arcs_reg, out_arcs_next;

    // token counts
    logic [TOKEN_BITS-1:0] cnt_reg  [NUM_PLACES];
    logic [TOKEN_BITS-1:0] cnt_next [NUM_PLACES];

    // per-item working registers
    logic                 func_reg, func_next;
    logic [PLACE_W-1:0]   place_reg, place_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [MAX_TRANS-1:0] enabled_reg, enabled_next;
    logic [TRANS_W-1:0]   which_reg, which_next;
    logic                 ovf_reg, ovf_next;
    result_t              result_reg, result_next;

    logic [NUM_PLACES-1:0] in_row  [MAX_TRANS];
    logic [NUM_PLACES-1:0] out_row [MAX_TRANS];
    logic [NUM_PLACES-1:0] nonzero;
    logic [MAX_TRANS-1:0]  en_now;
    logic [COUNT_W-1:0]    cnt_now;
    logic [MARK_W-1:0]     marking;

    // arc rows, clipped to the places in the net
    always_comb begin
        for (int t = 0; t < MAX_TRANS; t++) begin
            in_row[t]  = in_arcs_reg[t*8 +: NUM_PLACES];
            out_row[t] = out_arcs_reg[t*8 +: NUM_PLACES];
        end
    end

    // enable check on the current marking
    always_comb begin
        for (int p = 0; p < NUM_PLACES; p++) begin
            nonzero[p] = (cnt_reg[p] != '0);
        end
        en_now  = '0;
        cnt_now = '0;
        for (int t = 0; t < NUM_TRANSITIONS; t++) begin
            en_now[t] = tmask_reg[t] && ((in_row[t] & ~nonzero) == '0);
        end
        for (int t = 0; t < MAX_TRANS; t++) begin
            cnt_now = cnt_now + COUNT_W'(en_now[t]);
        end
    end

    always_comb begin
        marking = '0;
        for (int p = 0; p < NUM_PLACES; p++) begin
            marking[p*8 +: TOKEN_BITS] = cnt_reg[p];
        end
    end

    // configuration writes
    always_comb begin
        tmask_next    = tmask_reg;
        in_arcs_next  = in_arcs_reg;
        out_arcs_next = out_arcs_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TMASK:    tmask_next    = cfg_data[MAX_TRANS-1:0];
                CFG_IN_ARCS:  in_arcs_next  = cfg_data;
                CFG_OUT_ARCS: out_arcs_next = cfg_data;
                default: ;
            endcase
        end
    end

    // item processing
    always_comb begin
        logic [COUNT_W-1:0] r;
        logic [COUNT_W-1:0] rank;
        logic               found;
        logic [TOKEN_BITS-1:0] c;

        func_next    = func_reg;
        place_next   = place_reg;
        rnd_next     = rnd_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        which_next   = which_reg;
        ovf_next     = ovf_reg;
        result_next  = result_reg;
        cnt_next     = cnt_reg;
        r            = rem_reg;
        rank         = rem_reg;
        found        = 1'b0;
        c            = '0;

        if (cmd.load) begin
            func_next    = in_func;
            place_next   = in_place;
            rnd_next     = in_rnd;
            rem_next     = '0;
            step_next    = '0;
            count_next   = cnt_now;
            enabled_next = en_now;
            which_next   = '0;
            ovf_next     = 1'b0;
        end

        // restoring remainder, one digit per step, MSB first
        if (cmd.mod_step) begin
            for (int k = 0; k < DIGIT_W; k++) begin
                r = {r[COUNT_W-2:0], rnd_reg[RND_W-1-k]};
                if (r >= count_reg) begin
                    r = r - count_reg;
                end
            end
            rem_next  = r;
            rnd_next  = rnd_reg << DIGIT_W;
            step_next = step_reg + 1'b1;
        end

        // rank-th enabled transition counting from the lowest index
        if (cmd.pick) begin
            for (int t = 0; t < MAX_TRANS; t++) begin
                if (enabled_reg[t] && !found) begin
                    if (rank == '0) begin
                        which_next = TRANS_W'(t);
                        found      = 1'b1;
                    end else begin
                        rank = rank - 1'b1;
                    end
                end
            end
        end

        // remove from input places, then add to output places
        if (cmd.fire) begin
            for (int p = 0; p < NUM_PLACES; p++) begin
                c = cnt_reg[p];
                if (in_row[which_reg][p] && c != '0) begin
                    c = c - 1'b1;
                end
                if (out_row[which_reg][p]) begin
                    if (c == MAX_COUNT) begin
                        ovf_next = 1'b1;
                    end else begin
                        c = c + 1'b1;
                    end
                end
                cnt_next[p] = c;
            end
        end

        if (cmd.add) begin
            for (int p = 0; p < NUM_PLACES; p++) begin
                if (PLACE_W'(p) == place_reg) begin
                    if (cnt_reg[p] == MAX_COUNT) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next[p] = cnt_reg[p] + 1'b1;
                    end
                end
            end
        end

        if (cmd.out_load) begin
            result_next.pad              = '0;
            result_next.marking          = marking;
            result_next.overflow         = ovf_reg;
            result_next.enabled_set      = enabled_reg;
            result_next.deadlock         = (func_reg == FUNC_FIRE) && (count_reg == '0);
            result_next.fired_transition = which_reg;
            result_next.fired            = (func_reg == FUNC_FIRE) && (count_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmask_reg    <= '0;
            in_arcs_reg  <= '0;
            out_arcs_reg <= '0;
            step_reg     <= '0;
            for (int p = 0; p < NUM_PLACES; p++) begin
                cnt_reg[p] <= '0;
            end
        end else begin
            tmask_reg    <= tmask_next;
            in_arcs_reg  <= in_arcs_next;
            out_arcs_reg <= out_arcs_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        place_reg   <= place_next;
        rnd_reg     <= rnd_next;
        rem_reg     <= rem_next;
        count_reg   <= count_next;
        enabled_reg <= enabled_next;
        which_reg   <= which_next;
        ovf_reg     <= ovf_next;
        result_reg  <= result_next;
    end

    assign status.in_func  = in_func;
    assign status.dead_now = (cnt_now == '0);
    assign status.mod_last = (step_reg == STEP_W'(MOD_STEPS - 1));
    assign result          = result_reg;

endmodule

// ----- rtl/core/petri_net_random_firing.sv -----
// Top level of the Petri net random firing engine: ports, controller and datapath.
// Depends on pnrf_pkg, pnrf_ctrl and pnrf_dp.
`timescale 1ns / 1ps

// Petri net token game with unit-weight arcs and up to 8 places and 8 transitions.
// Net structure is written over the cfg port (index 0 transition mask, 1 input
// arcs, 2 output arcs, bit t*8+p per arc; other indexes ignored); the user must
// write it only while no beat is in flight, as the block does not enforce this.
// cfg_ready is always high. Token counts reset to zero, no clearing pass. A fire
// beat (tuser 0) picks enabled transition number random_value mod enabled_count
// and fires it, or reports deadlock if none is enabled; an add beat (tuser 1)
// puts one token on place_index. Counts saturate at the top value and flag
// overflow. One result beat per input beat. A fire beat goes through accept, the
// remainder unit, which takes 4 random bits a cycle, then pick, token update and
// result load before the next accept. Add beats go through accept, token add and
// result load, deadlock beats through accept and result load. A finished result
// sits in the output register while the next beat is accepted and worked on;
// only loading the following result waits for m_tready.
module petri_net_random_firing
    import pnrf_pkg::*;
#(
    parameter int NUM_PLACES      = 8,
    parameter int NUM_TRANSITIONS = 8,
    parameter int TOKEN_BITS      = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [ARC_W-1:0]      cfg_data,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] place_index, [18:3] random_value
    input  logic                  s_tuser,   // [0] func
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] fired, [3:1] fired_transition,
                                             // [4] deadlock, [12:5] enabled_set,
                                             // [13] overflow, [77:14] marking
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    result_t      result;

    assign cfg_ready = 1'b1;

    pnrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pnrf_dp #(
        .NUM_PLACES      (NUM_PLACES),
        .NUM_TRANSITIONS (NUM_TRANSITIONS),
        .TOKEN_BITS      (TOKEN_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_func   (s_tuser),
        .in_place  (s_tdata[PLACE_W-1:0]),
        .in_rnd    (s_tdata[PLACE_W +: RND_W]),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_tdata = result;

    // a beat once taken blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // only one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a result never both fires and deadlocks
    a_fire_xor_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result.fired && result.deadlock))
        else $error("fired and deadlock both set");

    // no transition index without a firing
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !result.fired) |-> (result.fired_transition == '0))
        else $error("fired_transition set without firing");

    // a result is only loaded from a state that may hand it off
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten while held");

endmodule
